[src/fsabc_pkg.sv]
// ---------------------------------------------------------------------------
// fsabc_pkg
// Shared types and constants for the second-order absorbing boundary update.
// ---------------------------------------------------------------------------
package fsabc_pkg;

  localparam int FIELD_BITS    = 32;
  localparam int COEF_FRAC     = 28;
  localparam int HIST_BITS     = 4;
  localparam int CELL_BITS     = 12;
  localparam int HISTORY_COUNT = 12;
  localparam int ADDR_BITS     = HIST_BITS + CELL_BITS;
  localparam int SLOTS         = HISTORY_COUNT * (2 ** CELL_BITS);
  localparam int COURANT_BITS  = 31;
  localparam int R_BITS        = 29;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = 2;

  localparam logic [COURANT_BITS-1:0] COURANT_ONE = COURANT_BITS'(1) << 30;

  typedef logic signed [FIELD_BITS-1:0] field_t;

  typedef struct packed {
    logic                    ok;
    logic [ADDR_BITS-1:0]    addr;
    logic [COURANT_BITS-1:0] p;
    field_t                  e1;
    field_t                  e2;
  } item_t;

  typedef struct packed {
    field_t v0;
    field_t v1;
    field_t v2;
  } row_t;

  typedef struct packed {
    row_t prev;
    row_t cur;
  } hist_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fr_req_t;

  typedef struct packed {
    logic adv;
    logic clearing;
  } bk_stat_t;

endpackage

[src/fsabc_if.sv]
// ---------------------------------------------------------------------------
// fsabc channel interfaces
// Valid/ready channels for boundary cells in and boundary values out.
// ---------------------------------------------------------------------------
interface fsabc_in_if import fsabc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [HIST_BITS-1:0]    history_select;
  logic [CELL_BITS-1:0]    cell_index;
  logic [COURANT_BITS-1:0] courant;
  logic signed [FIELD_BITS-1:0] inner_one;
  logic signed [FIELD_BITS-1:0] inner_two;

  modport source(output valid, history_select, cell_index, courant, inner_one, inner_two,
                 input ready);
  modport sink(input valid, history_select, cell_index, courant, inner_one, inner_two,
               output ready);
endinterface

interface fsabc_out_if import fsabc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] boundary_value;

  modport source(output valid, boundary_value, input ready);
  modport sink(input valid, boundary_value, output ready);
endinterface

[src/fdtd_second_order_abc_update_top.sv]
// ---------------------------------------------------------------------------
// fdtd_second_order_abc_update_top
// Second-order absorbing boundary update for twelve boundary histories.
// ---------------------------------------------------------------------------
// One boundary cell is accepted per clock while the input queue has room and
// no clearing pass runs, and one saturated Q8.24 boundary value comes out per
// cell, in order. From acceptance a cell passes through the input queue, the
// bit-per-stage divider that forms r from the Courant product, the squaring,
// memory read, difference, multiply and sum stages, and the output register.
// A cell whose history slot matches one of the up to four transactions
// between the memory read and its write-back waits until that write-back.
// After reset all 49152 slots of the history memory are cleared, and no cell
// is accepted during the clearing pass.
module fdtd_second_order_abc_update_top import fsabc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  fsabc_in_if.sink    in_ch,
  fsabc_out_if.source out_ch
);

  fr_req_t  req;
  bk_stat_t stat;

  fsabc_front u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .stat (stat),
    .req  (req)
  );

  fsabc_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .stat  (stat),
    .out_ch(out_ch)
  );

endmodule

[src/fsabc_front.sv]
// ---------------------------------------------------------------------------
// fsabc_front
// Accepts boundary cells, clamps the Courant product, forms the history
// address and queues the transaction for the back end.
// ---------------------------------------------------------------------------
module fsabc_front import fsabc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  fsabc_in_if.sink in_ch,
  input  bk_stat_t stat,
  output fr_req_t  req
);

  item_t                q_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_BITS:0]   cnt_r, cnt_nxt;
  logic                 push, pop;
  item_t                cls;

  assign in_ch.ready = (cnt_r != (QPTR_BITS+1)'(QUEUE_DEPTH)) && !stat.clearing;
  assign push        = in_ch.valid && in_ch.ready;
  assign req.valid   = (cnt_r != '0);
  assign req.item    = q_r[rd_ptr_r];
  assign pop         = req.valid && stat.adv;

  always_comb begin
    cls.ok   = (in_ch.history_select < HIST_BITS'(HISTORY_COUNT));
    cls.addr = {in_ch.history_select, in_ch.cell_index};
    if (in_ch.courant == '0) begin
      cls.p = COURANT_BITS'(1);
    end else if (in_ch.courant > COURANT_ONE) begin
      cls.p = COURANT_ONE;
    end else begin
      cls.p = in_ch.courant;
    end
    cls.e1 = in_ch.inner_one;
    cls.e2 = in_ch.inner_two;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

[src/fsabc_div.sv]
// ---------------------------------------------------------------------------
// fsabc_div
// Pipelined restoring divider for the reflection ratio
// r = round((1 - c) / (1 + c)), one quotient bit per stage.
// ---------------------------------------------------------------------------
module fsabc_div import fsabc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  item_t             in_item,
  output logic              out_valid,
  output item_t             out_item,
  output logic [R_BITS-1:0] out_r
);

  localparam int STAGES   = R_BITS;
  localparam int NUM_BITS = COURANT_BITS + COEF_FRAC;
  localparam int DEN_BITS = COURANT_BITS + 1;
  localparam int REM_BITS = DEN_BITS - 1;

  logic                v_r    [STAGES];
  item_t               item_r [STAGES];
  logic [REM_BITS-1:0] rem_r  [STAGES];
  logic [R_BITS-1:0]   low_r  [STAGES];
  logic [R_BITS-1:0]   q_r    [STAGES];

  logic                v_nxt    [STAGES];
  item_t               item_nxt [STAGES];
  logic [REM_BITS-1:0] rem_nxt  [STAGES];
  logic [R_BITS-1:0]   low_nxt  [STAGES];
  logic [R_BITS-1:0]   q_nxt    [STAGES];

  logic [NUM_BITS-1:0] num0;
  logic [DEN_BITS-1:0] den0;
  logic [DEN_BITS-1:0] den   [STAGES];
  logic [DEN_BITS-1:0] trial [STAGES];
  logic [REM_BITS-1:0] src_rem [STAGES];
  logic [R_BITS-1:0]   src_low [STAGES];
  logic [R_BITS-1:0]   src_q   [STAGES];
  item_t               src_item [STAGES];
  logic                src_v    [STAGES];

  // numerator carries the rounding half of the divisor
  always_comb begin
    den0 = DEN_BITS'(COURANT_ONE) + DEN_BITS'(in_item.p);
    num0 = {COURANT_ONE - in_item.p, COEF_FRAC'(0)} + NUM_BITS'(den0 >> 1);
  end

  always_comb begin
    for (int s = 0; s < STAGES; s++) begin
      if (s == 0) begin
        src_v[s]    = in_valid;
        src_item[s] = in_item;
        src_rem[s]  = REM_BITS'(num0[NUM_BITS-1:R_BITS]);
        src_low[s]  = num0[R_BITS-1:0];
        src_q[s]    = '0;
      end else begin
        src_v[s]    = v_r[s-1];
        src_item[s] = item_r[s-1];
        src_rem[s]  = rem_r[s-1];
        src_low[s]  = low_r[s-1];
        src_q[s]    = q_r[s-1];
      end
      den[s]      = DEN_BITS'(COURANT_ONE) + DEN_BITS'(src_item[s].p);
      trial[s]    = {src_rem[s], src_low[s][R_BITS-1]};
      v_nxt[s]    = src_v[s];
      item_nxt[s] = src_item[s];
      low_nxt[s]  = {src_low[s][R_BITS-2:0], 1'b0};
      if (trial[s] >= den[s]) begin
        rem_nxt[s] = REM_BITS'(trial[s] - den[s]);
        q_nxt[s]   = {src_q[s][R_BITS-2:0], 1'b1};
      end else begin
        rem_nxt[s] = REM_BITS'(trial[s]);
        q_nxt[s]   = {src_q[s][R_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STAGES; s++) begin
        v_r[s] <= 1'b0;
      end
    end else if (adv) begin
      for (int s = 0; s < STAGES; s++) begin
        v_r[s] <= v_nxt[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < STAGES; s++) begin
        item_r[s] <= item_nxt[s];
        rem_r[s]  <= rem_nxt[s];
        low_r[s]  <= low_nxt[s];
        q_r[s]    <= q_nxt[s];
      end
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_item  = item_r[STAGES-1];
  assign out_r     = q_r[STAGES-1];

endmodule

[src/fsabc_back.sv]
// ---------------------------------------------------------------------------
// fsabc_back
// Coefficient pipeline, history memory with read-modify-write, weighted sum,
// rounding and saturation, and the output register.
// ---------------------------------------------------------------------------
module fsabc_back import fsabc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fr_req_t     req,
  output bk_stat_t    stat,
  fsabc_out_if.source out_ch
);

  localparam int X_BITS   = FIELD_BITS + 1;
  localparam int Y_BITS   = FIELD_BITS + 3;
  localparam int C_BITS   = R_BITS + 2;
  localparam int M1_BITS  = R_BITS + 1 + X_BITS;
  localparam int M2_BITS  = R_BITS + 1 + Y_BITS;
  localparam int M3_BITS  = C_BITS + FIELD_BITS;
  localparam int ACC_BITS = M2_BITS + 4;
  localparam int SQ_BITS  = 2 * R_BITS;

  logic en_tail, en_head, hazard;

  logic              dv;
  item_t             ditem;
  logic [R_BITS-1:0] dr;

  fsabc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (en_head),
    .in_valid (req.valid),
    .in_item  (req.item),
    .out_valid(dv),
    .out_item (ditem),
    .out_r    (dr)
  );

  // stage 0: r squared, memory read address
  logic              s0_v_r;
  item_t             s0_item_r;
  logic [R_BITS-1:0] s0_r_r, s0_r2_r, r2_nxt;
  logic [SQ_BITS-1:0] sq;

  always_comb begin
    sq     = SQ_BITS'(dr) * SQ_BITS'(dr) + (SQ_BITS'(1) << (COEF_FRAC - 1));
    r2_nxt = R_BITS'(sq >> COEF_FRAC);
  end

  // history memory and clearing pass
  hist_t                mem [SLOTS];
  hist_t                rd_r;
  logic                 clearing_r;
  logic [ADDR_BITS-1:0] clr_cnt_r;
  logic                 wr_en;
  hist_t                wr_data;

  // stage 1
  logic              s1_v_r;
  item_t             s1_item_r;
  logic [R_BITS-1:0] s1_r_r, s1_r2_r;
  row_t              p_row, q_row;
  logic signed [X_BITS-1:0] x_nxt;
  logic signed [Y_BITS-1:0] y_nxt;

  // stage 2
  logic              s2_v_r;
  item_t             s2_item_r;
  logic [R_BITS-1:0] s2_r_r, s2_r2_r;
  logic signed [X_BITS-1:0] s2_x_r;
  logic signed [Y_BITS-1:0] s2_y_r;
  row_t              s2_q_r;
  field_t            s2_p2_r;
  logic [C_BITS-1:0] c3;
  logic signed [M1_BITS-1:0] m1_nxt;
  logic signed [M2_BITS-1:0] m2_nxt;
  logic signed [M3_BITS-1:0] m3_nxt;

  // stage 3
  logic              s3_v_r;
  item_t             s3_item_r;
  row_t              s3_q_r;
  field_t            s3_p2_r;
  logic signed [M1_BITS-1:0] s3_m1_r;
  logic signed [M2_BITS-1:0] s3_m2_r;
  logic signed [M3_BITS-1:0] s3_m3_r;
  logic signed [ACC_BITS-1:0] acc_nxt;

  // stage 4: write-back and output
  logic              s4_v_r;
  item_t             s4_item_r;
  row_t              s4_q_r;
  logic signed [ACC_BITS-1:0] s4_acc_r;
  logic signed [ACC_BITS-1:0] sh;
  field_t            res;

  logic   out_valid_r;
  field_t out_value_r;

  function automatic logic same_slot(logic v, item_t a, item_t b);
    return v && a.ok && (a.addr == b.addr);
  endfunction

  assign hazard = s0_v_r && s0_item_r.ok &&
                  (same_slot(s1_v_r, s1_item_r, s0_item_r) ||
                   same_slot(s2_v_r, s2_item_r, s0_item_r) ||
                   same_slot(s3_v_r, s3_item_r, s0_item_r) ||
                   same_slot(s4_v_r, s4_item_r, s0_item_r));
  assign en_tail       = !out_valid_r || out_ch.ready;
  assign en_head       = en_tail && !hazard;
  assign stat.adv      = en_head;
  assign stat.clearing = clearing_r;

  // out-of-range histories read as all zero
  always_comb begin
    p_row = s1_item_r.ok ? rd_r.prev : '0;
    q_row = s1_item_r.ok ? rd_r.cur  : '0;
    x_nxt = X_BITS'($signed(s1_item_r.e2)) + X_BITS'($signed(p_row.v0));
    y_nxt = Y_BITS'($signed(q_row.v0)) + Y_BITS'($signed(q_row.v2))
          - Y_BITS'($signed(s1_item_r.e1)) - Y_BITS'($signed(p_row.v1));
  end

  always_comb begin
    c3     = (C_BITS'(1) << COEF_FRAC) + C_BITS'(s2_r2_r);
    m1_nxt = M1_BITS'($signed({1'b0, s2_r2_r})) * M1_BITS'(s2_x_r);
    m2_nxt = M2_BITS'($signed({1'b0, s2_r_r})) * M2_BITS'(s2_y_r);
    m3_nxt = M3_BITS'($signed({1'b0, c3})) * M3_BITS'($signed(s2_q_r.v1));
  end

  always_comb begin
    acc_nxt = -ACC_BITS'(s3_m1_r)
            + (ACC_BITS'(s3_m2_r) <<< 1)
            + (ACC_BITS'(s3_m3_r) <<< 1)
            - (ACC_BITS'($signed(s3_p2_r)) <<< COEF_FRAC)
            + (ACC_BITS'(1) <<< (COEF_FRAC - 1));
  end

  always_comb begin
    sh = s4_acc_r >>> COEF_FRAC;
    if ((&sh[ACC_BITS-1:FIELD_BITS-1]) || !(|sh[ACC_BITS-1:FIELD_BITS-1])) begin
      res = sh[FIELD_BITS-1:0];
    end else if (sh[ACC_BITS-1]) begin
      res = {1'b1, {(FIELD_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(FIELD_BITS-1){1'b1}}};
    end
    wr_en          = en_tail && s4_v_r && s4_item_r.ok;
    wr_data.prev   = s4_q_r;
    wr_data.cur.v0 = res;
    wr_data.cur.v1 = s4_item_r.e1;
    wr_data.cur.v2 = s4_item_r.e2;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
    end else begin
      if (en_head) begin
        s0_v_r <= dv;
      end
      if (en_tail) begin
        s1_v_r      <= en_head ? s0_v_r : 1'b0;
        s2_v_r      <= s1_v_r;
        s3_v_r      <= s2_v_r;
        s4_v_r      <= s3_v_r;
        out_valid_r <= s4_v_r;
      end
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_BITS'(SLOTS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en_head) begin
      s0_item_r <= ditem;
      s0_r_r    <= dr;
      s0_r2_r   <= r2_nxt;
      s1_item_r <= s0_item_r;
      s1_r_r    <= s0_r_r;
      s1_r2_r   <= s0_r2_r;
    end
    if (en_tail) begin
      s2_item_r   <= s1_item_r;
      s2_r_r      <= s1_r_r;
      s2_r2_r     <= s1_r2_r;
      s2_x_r      <= x_nxt;
      s2_y_r      <= y_nxt;
      s2_q_r      <= q_row;
      s2_p2_r     <= p_row.v2;
      s3_item_r   <= s2_item_r;
      s3_q_r      <= s2_q_r;
      s3_p2_r     <= s2_p2_r;
      s3_m1_r     <= m1_nxt;
      s3_m2_r     <= m2_nxt;
      s3_m3_r     <= m3_nxt;
      s4_item_r   <= s3_item_r;
      s4_q_r      <= s3_q_r;
      s4_acc_r    <= acc_nxt;
      out_value_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[s4_item_r.addr] <= wr_data;
    end
    if (en_head) begin
      rd_r <= mem[s0_item_r.addr];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.boundary_value = out_value_r;

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !s4_v_r)
    else $error("transaction in write-back during clearing pass");

  a_no_dup_slot: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s2_v_r && s1_item_r.ok && s2_item_r.ok |-> s1_item_r.addr != s2_item_r.addr)
    else $error("two transactions in flight on one history slot");

  a_wb_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && !en_tail |=> s4_v_r && $stable(s4_acc_r))
    else $error("write-back stage lost its sum while stalled");

endmodule

[tb/fsabc_tb_if.sv]
// ---------------------------------------------------------------------------
// fsabc testbench channel note
// The channel interfaces themselves live with the RTL; this file holds the
// stimulus record shared by the testbench.
// ---------------------------------------------------------------------------
package fsabc_tb_pkg;
  import fsabc_pkg::*;

  typedef struct {
    logic [HIST_BITS-1:0]    sel;
    logic [CELL_BITS-1:0]    cidx;
    logic [COURANT_BITS-1:0] p;
    field_t                  e1;
    field_t                  e2;
    logic                    has_exp;
    field_t                  exp_v;
  } cell_req_t;
endpackage

[tb/fdtd_second_order_abc_update_top_tb.sv]
// ---------------------------------------------------------------------------
// fdtd_second_order_abc_update_top_tb
// Drives boundary cells with random gaps and stalls, predicts each boundary
// value from a local copy of the cell histories and checks every result.
// ---------------------------------------------------------------------------
module fdtd_second_order_abc_update_top_tb;
  import fsabc_pkg::*;
  import fsabc_tb_pkg::*;

  localparam int N_RANDOM  = 1950;
  localparam int WDOG_MAX  = 200000;
  localparam int N_TABLE   = 16;

  logic clk;
  logic rst_n;
  fsabc_in_if  in_ch ();
  fsabc_out_if out_ch ();

  fdtd_second_order_abc_update_top i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Histories: previous and current rows, three entries per slot
  longint hist_prev[int][3];
  longint hist_cur[int][3];
  field_t boundary_q[$];
  int     fails;
  int     wdog;
  bit     stim_done;

  cell_req_t stim_table[N_TABLE];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic field_t predict_boundary(cell_req_t c);
    longint p, den, r, r2, x, y, acc, res, e1, e2, half;
    longint pr[3];
    longint cr[3];
    int     slot;
    bit     ok;
    ok = (c.sel < HISTORY_COUNT);
    slot = c.sel * 4096 + c.cidx;
    for (int j = 0; j < 3; j++) begin
      pr[j] = 0;
      cr[j] = 0;
      if (ok && hist_prev.exists(slot)) begin
        pr[j] = hist_prev[slot][j];
        cr[j] = hist_cur[slot][j];
      end
    end
    e1 = c.e1;
    e2 = c.e2;
    p = c.p;
    if (p < 1) p = 1;
    if (p > (64'd1 << 30)) p = 64'd1 << 30;
    den = (64'd1 << 30) + p;
    r = ((((64'd1 << 30) - p) << COEF_FRAC) + den / 2) / den;
    r2 = (r * r + (64'd1 << (COEF_FRAC - 1))) >>> COEF_FRAC;
    x = e2 + pr[0];
    y = cr[0] + cr[2] - e1 - pr[1];
    half = 64'd1 << (COEF_FRAC - 1);
    acc = -r2 * x + 2 * r * y + 2 * ((64'd1 << COEF_FRAC) + r2) * cr[1]
          - pr[2] * (64'd1 << COEF_FRAC);
    res = (acc + half) >>> COEF_FRAC;
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    if (ok) begin
      for (int j = 0; j < 3; j++) hist_prev[slot][j] = cr[j];
      hist_cur[slot][0] = res;
      hist_cur[slot][1] = e1;
      hist_cur[slot][2] = e2;
    end
    return field_t'(res);
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic cell_req_t random_cell();
    cell_req_t c;
    int k;
    k = $urandom_range(0, 99);
    // most cells revisit a small set of slots so histories build up
    c.sel = (k < 5) ? HIST_BITS'($urandom_range(12, 15)) : HIST_BITS'($urandom_range(0, 11));
    c.cidx = (k < 70) ? CELL_BITS'($urandom_range(0, 3)) : CELL_BITS'($urandom());
    k = $urandom_range(0, 9);
    if (k == 0) c.p = COURANT_BITS'($urandom());
    else if (k == 1) c.p = COURANT_ONE;
    else if (k == 2) c.p = 1;
    else c.p = COURANT_BITS'($urandom_range(1, 32'h4000_0000));
    k = $urandom_range(0, 3);
    c.e1 = (k == 0) ? field_t'($urandom()) : field_t'($signed($urandom_range(0, 2**26)) - 2**25);
    c.e2 = (k == 0) ? field_t'($urandom()) : field_t'($signed($urandom_range(0, 2**26)) - 2**25);
    c.has_exp = 1'b0;
    c.exp_v = '0;
    return c;
  endfunction

  task automatic send_cell(cell_req_t c);
    field_t v;
    in_ch.valid          <= 1'b1;
    in_ch.history_select <= c.sel;
    in_ch.cell_index     <= c.cidx;
    in_ch.courant        <= c.p;
    in_ch.inner_one      <= c.e1;
    in_ch.inner_two      <= c.e2;
    do @(posedge clk); while (!in_ch.ready);
    v = predict_boundary(c);
    if (c.has_exp && v != c.exp_v) begin
      $error("boundary_value (table): expected %0d, predictor %0d", c.exp_v, v);
      fails++;
    end
    boundary_q.push_back(c.has_exp ? c.exp_v : v);
    @(negedge clk);
  endtask

  // Sender
  initial begin
    int g;
    cell_req_t c;
    fails = 0;
    stim_done = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.history_select = '0;
    in_ch.cell_index = '0;
    in_ch.courant = '0;
    in_ch.inner_one = '0;
    in_ch.inner_two = '0;
    // zero history: result is the rounded -r^2*E2 + -2r*E1 term; zero inputs give zero
    stim_table[0]  = '{0, 0, 1, 0, 0, 1, 0};
    stim_table[1]  = '{11, 4095, COURANT_ONE, 0, 0, 1, 0};
    // c = 1 makes r = 0, so a fresh cell returns zero regardless of inputs
    stim_table[2]  = '{5, 7, COURANT_ONE, 32'h7fff_ffff, 32'h8000_0000, 1, 0};
    stim_table[3]  = '{5, 7, COURANT_ONE, 32'h8000_0000, 32'h7fff_ffff, 0, 0};
    stim_table[4]  = '{5, 7, 1, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0};
    stim_table[5]  = '{5, 7, 1, 32'h8000_0000, 32'h8000_0000, 0, 0};
    stim_table[6]  = '{0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0};
    stim_table[7]  = '{0, 0, 31'h7fff_ffff, 32'h8000_0000, 32'h0100_0000, 0, 0};
    stim_table[8]  = '{12, 0, 1, 32'h7fff_ffff, 32'h8000_0000, 0, 0};
    stim_table[9]  = '{15, 4095, 31'h2000_0000, 32'h0100_0000, 32'h0200_0000, 0, 0};
    stim_table[10] = '{3, 100, 31'h2000_0000, 32'h0100_0000, 32'h0200_0000, 0, 0};
    stim_table[11] = '{3, 100, 31'h2000_0000, 32'hff00_0000, 32'h0080_0000, 0, 0};
    stim_table[12] = '{3, 100, 31'h2000_0000, 32'h0, 32'h0, 0, 0};
    stim_table[13] = '{3, 100, 31'h1, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0};
    stim_table[14] = '{11, 4095, 31'h0aaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 0, 0};
    stim_table[15] = '{11, 4095, 31'h3555_5555, 32'haaaa_aaaa, 32'h5555_5555, 0, 0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < N_TABLE; i++) send_cell(stim_table[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      g = gap_len();
      if (i == N_RANDOM / 2) begin
        // drain completely before going on
        in_ch.valid <= 1'b0;
        wait (boundary_q.size() == 0);
        @(negedge clk);
      end else if (g > 0) begin
        in_ch.valid <= 1'b0;
        repeat (g) @(negedge clk);
      end
      c = random_cell();
      send_cell(c);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver, with one long hold-off early on
  initial begin
    int g;
    out_ch.ready = 1'b0;
    wait (rst_n);
    repeat (200) @(negedge clk);
    wait (boundary_q.size() > 0);
    @(negedge clk);
    out_ch.ready <= 1'b0;
    repeat (150) @(negedge clk);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Result check and watchdog
  initial begin
    field_t want;
    wdog = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) wdog = 0;
      else wdog++;
      if (out_ch.valid && out_ch.ready) begin
        if (boundary_q.size() == 0) begin
          $error("boundary_value: no result expected, got %0d", out_ch.boundary_value);
          fails++;
        end else begin
          want = boundary_q.pop_front();
          if (out_ch.boundary_value !== want) begin
            $error("boundary_value: expected %0d, actual %0d", want, out_ch.boundary_value);
            fails++;
          end
        end
      end
      if (wdog >= WDOG_MAX) begin
        $display("Simulation FAILED");
        $finish;
      end
      if (stim_done && boundary_q.size() == 0 && wdog > 100) begin
        if (fails == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
